>>> rtl/uifb_pkg.sv
// shared types, constants and header helpers for the udp/ipv4 frame builder
package uifb_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_DEST_MAC    = 3'd0;
    localparam logic [2:0] CFG_SOURCE_MAC  = 3'd1;
    localparam logic [2:0] CFG_SOURCE_IP   = 3'd2;
    localparam logic [2:0] CFG_DEST_IP     = 3'd3;
    localparam logic [2:0] CFG_SRC_PORT    = 3'd4;
    localparam logic [2:0] CFG_DEST_PORT   = 3'd5;

    // input command codes
    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_PAYLOAD = 1'b1;

    // fixed field widths
    localparam int LEN_W  = 11;
    localparam int SEQ_W  = 32;
    localparam int BYTE_W = 8;
    localparam int POS_W  = 6;
    localparam int SUM_W  = 20;

    // fixed header field values
    localparam logic [7:0] ETHERTYPE_HI = 8'h08;
    localparam logic [7:0] IP_VER_IHL   = 8'h45;
    localparam logic [7:0] IP_FLAGS_DF  = 8'h40;
    localparam logic [7:0] IP_TTL       = 8'h1e;
    localparam logic [7:0] IP_PROTO_UDP = 8'd17;

    // ethernet header is 14 bytes, ipv4 header ends at byte 34
    localparam int ETH_HDR_BYTES = 14;
    localparam int IP_HDR_END    = 34;

    // constant part of the ipv4 header word sum
    localparam logic [SUM_W-1:0] IP_CONST_SUM = SUM_W'({IP_VER_IHL, 8'h00})
        + SUM_W'({IP_FLAGS_DF, 8'h00}) + SUM_W'({IP_TTL, IP_PROTO_UDP});

    // byte positions in the header
    localparam logic [POS_W-1:0] POS_ETHERTYPE = 6'd12;
    localparam logic [POS_W-1:0] POS_VER_IHL   = 6'd14;
    localparam logic [POS_W-1:0] POS_IPLEN_HI  = 6'd16;
    localparam logic [POS_W-1:0] POS_IPLEN_LO  = 6'd17;
    localparam logic [POS_W-1:0] POS_FLAGS     = 6'd20;
    localparam logic [POS_W-1:0] POS_TTL       = 6'd22;
    localparam logic [POS_W-1:0] POS_PROTO     = 6'd23;
    localparam logic [POS_W-1:0] POS_CSUM_HI   = 6'd24;
    localparam logic [POS_W-1:0] POS_CSUM_LO   = 6'd25;
    localparam logic [POS_W-1:0] POS_SPORT_HI  = 6'd34;
    localparam logic [POS_W-1:0] POS_SPORT_LO  = 6'd35;
    localparam logic [POS_W-1:0] POS_DPORT_HI  = 6'd36;
    localparam logic [POS_W-1:0] POS_DPORT_LO  = 6'd37;
    localparam logic [POS_W-1:0] POS_UDPLEN_HI = 6'd38;
    localparam logic [POS_W-1:0] POS_UDPLEN_LO = 6'd39;

    // queue depth between front and back end
    localparam int QUEUE_DEPTH = 4;

    // programmable address set
    typedef struct packed {
        logic [47:0] dest_mac;
        logic [47:0] source_mac;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [15:0] src_port;
        logic [15:0] dest_port;
    } uifb_cfg_t;

    // one job from front to back: a header run or one payload byte
    typedef struct packed {
        logic              is_hdr;
        logic              last;
        logic [LEN_W-1:0]  plen;
        logic [SEQ_W-1:0]  data;
    } uifb_job_t;

    // octet k of a mac address, k = 0 is the first sent
    function automatic logic [7:0] mac_octet(logic [47:0] mac, logic [2:0] k);
        logic [7:0] o;
        case (k)
            3'd0:    o = mac[47:40];
            3'd1:    o = mac[39:32];
            3'd2:    o = mac[31:24];
            3'd3:    o = mac[23:16];
            3'd4:    o = mac[15:8];
            default: o = mac[7:0];
        endcase
        return o;
    endfunction

    // octet k of a 32-bit word, k = 0 is the most significant
    function automatic logic [7:0] word_octet(logic [31:0] w, logic [1:0] k);
        logic [7:0] o;
        case (k)
            2'd0:    o = w[31:24];
            2'd1:    o = w[23:16];
            2'd2:    o = w[15:8];
            default: o = w[7:0];
        endcase
        return o;
    endfunction

endpackage

>>> rtl/udp_ipv4_frame_builder_top.sv
// top level of the ethernet/ipv4/udp transmit frame builder
// A start beat (tuser = 0) opens a frame: the block sends HEADER_BYTES header
// beats (ethernet, ipv4 with checksum, udp with zero checksum, then the sequence
// number padded with zeros), followed by one beat per payload beat (tuser = 1)
// up to the declared length, clamped to MAX_PAYLOAD; tlast marks the final beat.
// Payload beats with no open frame are dropped. The input side feeds a
// four-entry job queue and is ready whenever it has room; the back end moves
// one payload byte per cycle while the output is not stalled, and for a header
// it first loads the job and then sends one byte per cycle, likewise unless
// stalled. Configuration registers are written through cfg_we/cfg_addr/
// cfg_wdata; the user must write them only while no frame is in flight, the
// block itself does not enforce this.
module udp_ipv4_frame_builder_top #(
    parameter int HEADER_BYTES = 46,
    parameter int MAX_PAYLOAD  = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [47:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // payload_length[10:0], sequence_number[42:11],
                                  // payload_byte[50:43], zero fill above
    input  logic        s_tuser,  // command
    // frame stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // frame_byte
    output logic        m_tlast
);
    import uifb_pkg::*;

    uifb_cfg_t cfg_reg;
    logic      push, q_full, pop, head_valid;
    uifb_job_t push_job, head_job;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_DEST_MAC:    cfg_reg.dest_mac    <= cfg_wdata;
                CFG_SOURCE_MAC:  cfg_reg.source_mac  <= cfg_wdata;
                CFG_SOURCE_IP:   cfg_reg.source_ip   <= cfg_wdata[31:0];
                CFG_DEST_IP:     cfg_reg.dest_ip     <= cfg_wdata[31:0];
                CFG_SRC_PORT:    cfg_reg.src_port    <= cfg_wdata[15:0];
                CFG_DEST_PORT:   cfg_reg.dest_port   <= cfg_wdata[15:0];
                default:         ;
            endcase
        end
    end

    uifb_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_cmd   (s_tuser),
        .in_len   (s_tdata[10:0]),
        .in_seq   (s_tdata[42:11]),
        .in_byte  (s_tdata[50:43]),
        .in_ready (s_tready),
        .push     (push),
        .push_job (push_job),
        .q_full   (q_full)
    );

    uifb_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    uifb_back #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

>>> rtl/uifb_front.sv
// front end: accepts input beats, tracks the open frame and queues jobs
module uifb_front #(
    parameter int MAX_PAYLOAD = 1024
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    input  logic                   in_cmd,
    input  logic [10:0]            in_len,
    input  logic [31:0]            in_seq,
    input  logic [7:0]             in_byte,
    output logic                   in_ready,
    output logic                   push,
    output uifb_pkg::uifb_job_t    push_job,
    input  logic                   q_full
);
    import uifb_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

    logic [LEN_W-1:0] remaining_reg, remaining_next;
    logic             active_reg, active_next;
    logic             accept;
    logic [LEN_W-1:0] plen_clamped;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign plen_clamped = (in_len > MAX_LEN) ? MAX_LEN : in_len;

    // classify the beat and build the job
    always_comb begin
        remaining_next = remaining_reg;
        active_next    = active_reg;
        push           = 1'b0;
        push_job       = '0;
        if (accept) begin
            if (in_cmd == CMD_START) begin
                push            = 1'b1;
                push_job.is_hdr = 1'b1;
                push_job.plen   = plen_clamped;
                push_job.data   = in_seq;
                push_job.last   = (plen_clamped == '0);
                remaining_next  = plen_clamped;
                active_next     = (plen_clamped != '0);
            end else if (active_reg && remaining_reg != '0) begin
                push               = 1'b1;
                push_job.data      = SEQ_W'(in_byte);
                push_job.last      = (remaining_reg == LEN_W'(1));
                remaining_next     = remaining_reg - LEN_W'(1);
                active_next        = (remaining_reg != LEN_W'(1));
            end else begin
                active_next = 1'b0;
            end
        end
    end

    // frame tracking state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remaining_reg <= '0;
            active_reg    <= 1'b0;
        end else begin
            remaining_reg <= remaining_next;
            active_reg    <= active_next;
        end
    end

endmodule

>>> rtl/uifb_queue.sv
// short job queue between front and back end
module uifb_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  uifb_pkg::uifb_job_t    push_job,
    output logic                   full,
    input  logic                   pop,
    output logic                   head_valid,
    output uifb_pkg::uifb_job_t    head_job
);
    import uifb_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    uifb_job_t        mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

>>> rtl/uifb_back.sv
// back end: plays out header bytes and payload bytes into the output register
module uifb_back #(
    parameter int HEADER_BYTES = 46
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  uifb_pkg::uifb_cfg_t    cfg,
    input  logic                   head_valid,
    input  uifb_pkg::uifb_job_t    head_job,
    output logic                   pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,
    output logic                   m_tlast
);
    import uifb_pkg::*;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(HEADER_BYTES - 1);
    localparam logic [15:0]      IP_BASE  = 16'(HEADER_BYTES - ETH_HDR_BYTES);
    localparam logic [15:0]      UDP_BASE = 16'(HEADER_BYTES - IP_HDR_END);

    logic             busy_reg;
    logic [POS_W-1:0] pos_reg;
    logic [LEN_W-1:0] plen_reg;
    logic [SEQ_W-1:0] seq_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] cfg_sum_reg;
    logic             valid_reg;
    logic [7:0]       data_reg;
    logic             last_reg;

    logic             adv;
    logic [15:0]      ip_len, udp_len, head_ip_len, csum;
    logic [7:0]       hdr_byte;

    assign adv         = !valid_reg || m_tready;
    assign ip_len      = IP_BASE + 16'(plen_reg);
    assign udp_len     = UDP_BASE + 16'(plen_reg);
    assign head_ip_len = IP_BASE + 16'(head_job.plen);
    assign csum        = ~sum_reg[15:0];

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

    // take a job from the queue when the back end is free
    assign pop = !busy_reg && head_valid && (head_job.is_hdr || adv);

    // header byte select
    always_comb begin
        case (pos_reg) inside
            [6'd0:6'd5]:   hdr_byte = mac_octet(cfg.dest_mac, 3'(pos_reg));
            [6'd6:6'd11]:  hdr_byte = mac_octet(cfg.source_mac, 3'(pos_reg - 6'd6));
            POS_ETHERTYPE: hdr_byte = ETHERTYPE_HI;
            POS_VER_IHL:   hdr_byte = IP_VER_IHL;
            POS_IPLEN_HI:  hdr_byte = ip_len[15:8];
            POS_IPLEN_LO:  hdr_byte = ip_len[7:0];
            POS_FLAGS:     hdr_byte = IP_FLAGS_DF;
            POS_TTL:       hdr_byte = IP_TTL;
            POS_PROTO:     hdr_byte = IP_PROTO_UDP;
            POS_CSUM_HI:   hdr_byte = csum[15:8];
            POS_CSUM_LO:   hdr_byte = csum[7:0];
            [6'd26:6'd29]: hdr_byte = word_octet(cfg.source_ip, 2'(pos_reg - 6'd26));
            [6'd30:6'd33]: hdr_byte = word_octet(cfg.dest_ip, 2'(pos_reg - 6'd30));
            POS_SPORT_HI:  hdr_byte = cfg.src_port[15:8];
            POS_SPORT_LO:  hdr_byte = cfg.src_port[7:0];
            POS_DPORT_HI:  hdr_byte = cfg.dest_port[15:8];
            POS_DPORT_LO:  hdr_byte = cfg.dest_port[7:0];
            POS_UDPLEN_HI: hdr_byte = udp_len[15:8];
            POS_UDPLEN_LO: hdr_byte = udp_len[7:0];
            [6'd42:6'd45]: hdr_byte = word_octet(seq_reg, 2'(pos_reg - 6'd42));
            default:       hdr_byte = 8'h00;
        endcase
    end

    // constant and address part of the ipv4 word sum, follows the registers
    always_ff @(posedge aclk) begin
        cfg_sum_reg <= IP_CONST_SUM
            + SUM_W'(cfg.source_ip[31:16]) + SUM_W'(cfg.source_ip[15:0])
            + SUM_W'(cfg.dest_ip[31:16]) + SUM_W'(cfg.dest_ip[15:0]);
    end

    // header job registers and checksum folding
    always_ff @(posedge aclk) begin
        if (pop && head_job.is_hdr) begin
            plen_reg <= head_job.plen;
            seq_reg  <= head_job.data;
            sum_reg  <= cfg_sum_reg + SUM_W'(head_ip_len);
        end else begin
            sum_reg  <= SUM_W'(sum_reg[15:0]) + SUM_W'(sum_reg[SUM_W-1:16]);
        end
    end

    // sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pos_reg  <= '0;
        end else if (busy_reg) begin
            if (adv) begin
                pos_reg <= pos_reg + POS_W'(1);
                if (pos_reg == LAST_POS) begin
                    busy_reg <= 1'b0;
                end
            end
        end else if (pop && head_job.is_hdr) begin
            busy_reg <= 1'b1;
            pos_reg  <= '0;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= busy_reg || (pop && !head_job.is_hdr);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (busy_reg) begin
                data_reg <= hdr_byte;
                last_reg <= (plen_reg == '0) && (pos_reg == LAST_POS);
            end else begin
                data_reg <= head_job.data[7:0];
                last_reg <= head_job.last;
            end
        end
    end

endmodule

>>> tb/tb_top.sv
// self-checking testbench for the udp/ipv4 transmit frame builder
`timescale 1ns / 1ps

module tb_top;
    import uifb_pkg::*;

    localparam int HDR_BYTES = 46;
    localparam int MAX_LEN   = 1024;
    // settling time after the last expected byte, to catch stray output beats
    localparam int SETTLE_CYCLES = 64;
    localparam int MAX_REPORTS   = 10;

    // indexes past the last register, written to check they are ignored
    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    typedef enum int {
        READY_ALWAYS,
        READY_HALF,
        READY_MOSTLY,
        READY_PERIODIC
    } ready_mode_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_beat_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_addr  = '0;
    logic [47:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    // predictor state
    uifb_cfg_t        addr_set;
    logic [LEN_W-1:0] remaining_bytes;
    logic             frame_open;
    frame_beat_t      frame_bytes_q[$];

    int mismatches   = 0;
    int useful_beats = 0;
    int burst_left   = 0;
    bit sender_eager = 1'b0;

    udp_ipv4_frame_builder_top #(
        .HEADER_BYTES(HDR_BYTES),
        .MAX_PAYLOAD (MAX_LEN)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #4 aclk = ~aclk;

    // header byte at position pos for a given frame length and checksum
    function automatic logic [7:0] header_octet(logic [POS_W-1:0] pos, logic [31:0] seq,
                                                logic [15:0] frame_len, logic [15:0] csum);
        logic [15:0] ip_len;
        logic [15:0] udp_len;
        logic [7:0]  o;
        ip_len  = frame_len - 16'(ETH_HDR_BYTES);
        udp_len = frame_len - 16'(IP_HDR_END);
        o = 8'h00;
        if (pos < 6)
            o = 8'(addr_set.dest_mac >> (8 * (5 - pos)));
        else if (pos < 12)
            o = 8'(addr_set.source_mac >> (8 * (11 - pos)));
        else if (pos >= 26 && pos < 30)
            o = 8'(addr_set.source_ip >> (8 * (29 - pos)));
        else if (pos >= 30 && pos < 34)
            o = 8'(addr_set.dest_ip >> (8 * (33 - pos)));
        else if (pos >= 42 && pos < 46)
            o = 8'(seq >> (8 * (45 - pos)));
        else begin
            case (pos)
                POS_ETHERTYPE: o = ETHERTYPE_HI;
                POS_VER_IHL:   o = IP_VER_IHL;
                POS_IPLEN_HI:  o = ip_len[15:8];
                POS_IPLEN_LO:  o = ip_len[7:0];
                POS_FLAGS:     o = IP_FLAGS_DF;
                POS_TTL:       o = IP_TTL;
                POS_PROTO:     o = IP_PROTO_UDP;
                POS_CSUM_HI:   o = csum[15:8];
                POS_CSUM_LO:   o = csum[7:0];
                POS_SPORT_HI:  o = addr_set.src_port[15:8];
                POS_SPORT_LO:  o = addr_set.src_port[7:0];
                POS_DPORT_HI:  o = addr_set.dest_port[15:8];
                POS_DPORT_LO:  o = addr_set.dest_port[7:0];
                POS_UDPLEN_HI: o = udp_len[15:8];
                POS_UDPLEN_LO: o = udp_len[7:0];
                default:       o = 8'h00;
            endcase
        end
        return o;
    endfunction

    // expected frame bytes caused by one accepted input beat; returns their count
    function automatic int frame_predict(logic cmd, logic [LEN_W-1:0] len_in,
                                         logic [31:0] seq, logic [7:0] data);
        logic [LEN_W-1:0] plen;
        logic [15:0]      frame_len;
        logic [SUM_W-1:0] sum;
        logic [15:0]      csum;
        frame_beat_t      beat;
        if (cmd == CMD_START) begin
            plen = (len_in > MAX_LEN) ? LEN_W'(MAX_LEN) : len_in;
            frame_len = 16'(HDR_BYTES) + 16'(plen);
            sum = '0;
            for (int k = ETH_HDR_BYTES; k < IP_HDR_END; k += 2)
                sum += {header_octet(POS_W'(k), seq, frame_len, 16'h0),
                        header_octet(POS_W'(k + 1), seq, frame_len, 16'h0)};
            // fold carries back into the low 16 bits
            while (sum[SUM_W-1:16] != 0)
                sum = (sum >> 16) + (sum & 20'hFFFF);
            csum = ~sum[15:0];
            for (int k = 0; k < HDR_BYTES; k++) begin
                beat.data = header_octet(POS_W'(k), seq, frame_len, csum);
                beat.last = (plen == 0) && (k == HDR_BYTES - 1);
                frame_bytes_q.push_back(beat);
            end
            remaining_bytes = plen;
            frame_open = (plen != 0);
            return HDR_BYTES;
        end
        // payload with no open frame is dropped
        if (!frame_open || remaining_bytes == 0) begin
            frame_open = 1'b0;
            return 0;
        end
        remaining_bytes = remaining_bytes - 1'b1;
        beat.data = data;
        beat.last = (remaining_bytes == 0);
        frame_bytes_q.push_back(beat);
        if (remaining_bytes == 0)
            frame_open = 1'b0;
        return 1;
    endfunction

    // send one input beat, with bursts and random gaps on the sender side
    task automatic send_beat(input logic cmd, input logic [LEN_W-1:0] len,
                             input logic [31:0] seq, input logic [7:0] data);
        int gap;
        int produced;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (!sender_eager && $urandom_range(0, 3) != 0)
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
        end
        burst_left--;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {5'b0, data, seq, len};
        do @(posedge aclk); while (!s_tready);
        produced = frame_predict(cmd, len, seq, data);
        if (produced != 0)
            useful_beats++;
        @(negedge aclk);
    endtask

    // start beat followed by a number of payload beats
    task automatic send_frame(input logic [LEN_W-1:0] len, input logic [31:0] seq,
                              input int payload_beats);
        send_beat(CMD_START, len, seq, 8'($urandom));
        repeat (payload_beats)
            send_beat(CMD_PAYLOAD, LEN_W'($urandom), $urandom, 8'($urandom));
    endtask

    // hold the sender until every expected byte is out and the block is quiet
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (frame_bytes_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        burst_left = 0;
        @(negedge aclk);
    endtask

    // write every address register, then the spare indexes with junk
    task automatic program_addresses(input logic [47:0] dmac, input logic [47:0] smac,
                                     input logic [47:0] sip, input logic [47:0] dip,
                                     input logic [47:0] sport, input logic [47:0] dport);
        logic [2:0]  idx [8];
        logic [47:0] val [8];
        idx = '{CFG_DEST_MAC, CFG_SOURCE_MAC, CFG_SOURCE_IP, CFG_DEST_IP,
                CFG_SRC_PORT, CFG_DEST_PORT, CFG_SPARE_LO, CFG_SPARE_HI};
        val = '{dmac, smac, sip, dip, sport, dport,
                48'({$urandom, $urandom}), 48'({$urandom, $urandom})};
        for (int i = 0; i < 8; i++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= idx[i];
            cfg_wdata <= val[i];
            case (idx[i])
                CFG_DEST_MAC:    addr_set.dest_mac    = val[i];
                CFG_SOURCE_MAC:  addr_set.source_mac  = val[i];
                CFG_SOURCE_IP:   addr_set.source_ip   = val[i][31:0];
                CFG_DEST_IP:     addr_set.dest_ip     = val[i][31:0];
                CFG_SRC_PORT:    addr_set.src_port    = val[i][15:0];
                CFG_DEST_PORT:   addr_set.dest_port   = val[i][15:0];
                default: ;
            endcase
            @(negedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    // frames with the address registers still at their reset values
    task automatic test_reset_defaults();
        send_frame(11'd0, 32'h0, 0);
        send_frame(11'd1, 32'hFFFF_FFFF, 1);
        wait_drained();
    endtask

    // hand-picked corner cases with every address bit set
    task automatic test_directed_frames();
        program_addresses({48{1'b1}}, {48{1'b1}}, {48{1'b1}}, {48{1'b1}},
                          {48{1'b1}}, {48{1'b1}});
        // payload before any frame is dropped
        send_beat(CMD_PAYLOAD, LEN_W'($urandom), $urandom, 8'hA5);
        // zero length: last flag sits on the final header byte
        send_frame(11'd0, 32'h0, 0);
        // extreme payload bytes, then surplus payload
        send_beat(CMD_START, 11'd2, 32'h1234_5678, 8'h00);
        send_beat(CMD_PAYLOAD, 11'h7FF, 32'hFFFF_FFFF, 8'h00);
        send_beat(CMD_PAYLOAD, 11'h000, 32'h0, 8'hFF);
        send_beat(CMD_PAYLOAD, 11'h7FF, 32'hFFFF_FFFF, 8'h5A);
        // start while a frame is open abandons it
        send_frame(11'd3, 32'h8000_0001, 1);
        send_frame(11'd1, 32'h7FFF_FFFE, 1);
        send_frame(11'd5, $urandom, 5);
        wait_drained();
    endtask

    // lengths at and above the maximum, and a zero length
    task automatic test_length_clamp();
        program_addresses(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 48'h0000_AAAA_AAAA,
                          48'h0000_5555_5555, 48'h0000_0000_AAAA, 48'h0000_0000_5555);
        // all length bits set: the header carries the clamped length
        send_frame(11'h7FF, $urandom, 4);
        wait_drained();
        send_frame(11'(MAX_LEN), $urandom, 3);
        send_frame(11'(MAX_LEN + 1), $urandom, 0);
        send_frame(11'd0, $urandom, 0);
        wait_drained();
    endtask

    // mostly well-formed frames, with truncated, overlong and stray payload mixed in
    task automatic test_random_traffic();
        int kind;
        int len;
        int beats;
        int start_count;
        for (int phase = 0; phase < 4; phase++) begin
            if (phase == 2)
                program_addresses('0, '0, '0, '0, '0, '0);
            else
                program_addresses(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                                  48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                                  48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
            sender_eager = (phase == 1);
            start_count = useful_beats;
            while (useful_beats - start_count < 85) begin
                kind = $urandom_range(0, 99);
                if (kind < 5) begin
                    send_beat(CMD_PAYLOAD, LEN_W'($urandom), $urandom, 8'($urandom));
                end else begin
                    case ($urandom_range(0, 99)) inside
                        [0:59]:  len = $urandom_range(0, 12);
                        [60:89]: len = $urandom_range(13, 64);
                        [90:96]: len = $urandom_range(65, 200);
                        default: len = $urandom_range(MAX_LEN + 1, 2047);
                    endcase
                    if (len > MAX_LEN)
                        beats = $urandom_range(0, 5);
                    else if (kind < 15 && len > 0)
                        beats = $urandom_range(0, len - 1);
                    else if (kind < 25)
                        beats = len + $urandom_range(1, 3);
                    else
                        beats = len;
                    send_frame(LEN_W'(len), $urandom, beats);
                end
            end
            wait_drained();
        end
        sender_eager = 1'b0;
    endtask

    // receiver stalls, switching to a random pattern after a random span
    initial begin
        ready_mode_t mode;
        int span;
        int tick;
        tick = 0;
        forever begin
            mode = ready_mode_t'($urandom_range(0, 3));
            span = $urandom_range(20, 300);
            repeat (span) begin
                @(negedge aclk);
                case (mode)
                    READY_ALWAYS:   m_tready <= 1'b1;
                    READY_HALF:     m_tready <= 1'($urandom_range(0, 1));
                    READY_MOSTLY:   m_tready <= ($urandom_range(0, 3) != 0);
                    READY_PERIODIC: m_tready <= ((tick % 11) < 7);
                    default:        m_tready <= 1'b1;
                endcase
                tick++;
            end
        end
    end

    // compare each output beat with the oldest expected frame byte
    always @(posedge aclk) begin
        frame_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (frame_bytes_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected output beat: data %h last %b", m_tdata, m_tlast);
            end else begin
                want = frame_bytes_q.pop_front();
                if (m_tdata !== want.data || m_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"output mismatch: expected data %h last %b,",
                                  " got data %h last %b"},
                                 want.data, want.last, m_tdata, m_tlast);
                end
            end
        end
    end

    // run limit
    initial begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        addr_set        = '0;
        remaining_bytes = '0;
        frame_open      = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_directed_frames();
        test_length_clamp();
        test_random_traffic();

        wait_drained();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
